// ===== hdl/mm4_pkg.sv =====
package mm4_pkg;

  localparam int DIM      = 4;
  localparam int CELLS    = DIM * DIM;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int CNT_W    = $clog2(DIM);
  localparam int ELEM_W   = 32;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = PROD_W + CNT_W;
  localparam int IDX_IN_W = 2;

  typedef logic [IDX_W-1:0]         cell_idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic first;
    logic last;
    cnt_t i;
    cnt_t j;
  } term_tag_t;

  function automatic cell_idx_t cell_addr(input cell_idx_t r, input cell_idx_t c);
    return IDX_W'(int'(r) * DIM + int'(c));
  endfunction

endpackage

// ===== hdl/matrix_multiply_4x4.sv =====
// Fixed-point 4x4 matrix product, result = left x right, elements signed s15.16.
// Each request writes one left and one right element at (row_i, col_i); both
// stores are cleared at reset and otherwise keep their contents between products.
// A request with last_load_i set starts the product, and busy_o then stays high
// while one shared 32x32 multiplier works through the DIM*DIM*DIM
// multiply-accumulates, one per cycle. The 16 result elements follow in row-major
// order through the product, sum and result registers behind the multiplier,
// each shown for exactly one cycle with result_valid_o high; the receiver cannot
// stall them. A request without last_load_i only stores its elements. Sums are
// exact, shifted right by 16 bits towards minus infinity and saturated to 32 bits.
module matrix_multiply_4x4
  import mm4_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [IDX_IN_W-1:0] row_i,
  input  logic [IDX_IN_W-1:0] col_i,
  input  logic [ELEM_W-1:0]   left_element_i,
  input  logic [ELEM_W-1:0]   right_element_i,
  input  logic                last_load_i,
  output logic                result_valid_o,
  output logic [IDX_IN_W-1:0] out_row_o,
  output logic [IDX_IN_W-1:0] out_col_o,
  output logic [ELEM_W-1:0]   product_element_o,
  output logic                last_result_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam cnt_t CNT_MAX = CNT_W'(DIM - 1);

  logic      state_q, state_d;
  cnt_t      i_q, i_d, j_q, j_d, k_q, k_d;
  elem_t     left_store_q  [CELLS];
  elem_t     right_store_q [CELLS];
  logic      accept;
  logic      in_range;
  cell_idx_t wr_addr;
  cell_idx_t left_addr;
  cell_idx_t right_addr;
  elem_t     mul_a;
  elem_t     mul_b;
  prod_t     prod_d, prod_q;
  logic      p_valid_q;
  term_tag_t p_tag_d, p_tag_q;
  acc_t      acc_d, acc_q;
  logic      acc_done_q;
  cnt_t      acc_i_q, acc_j_q;
  acc_t      shifted;
  logic      fits;
  elem_t     sat_value;
  logic      res_valid_q;
  logic [IDX_IN_W-1:0] res_row_q, res_col_q;
  elem_t     res_value_q;
  logic      res_last_q;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q == ST_RUN);
  assign in_range = (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign wr_addr  = cell_addr(IDX_W'(row_i), IDX_W'(col_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < CELLS; n++) begin
        left_store_q[n]  <= '0;
        right_store_q[n] <= '0;
      end
    end else if (accept && in_range) begin
      left_store_q[wr_addr]  <= elem_t'(left_element_i);
      right_store_q[wr_addr] <= elem_t'(right_element_i);
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_load_i) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        k_d = k_q + 1'b1;
        if (k_q == CNT_MAX) begin
          k_d = '0;
          j_d = j_q + 1'b1;
          if (j_q == CNT_MAX) begin
            j_d = '0;
            i_d = i_q + 1'b1;
            if (i_q == CNT_MAX) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign left_addr     = cell_addr(IDX_W'(i_q), IDX_W'(k_q));
  assign right_addr    = cell_addr(IDX_W'(k_q), IDX_W'(j_q));
  assign mul_a         = left_store_q[left_addr];
  assign mul_b         = right_store_q[right_addr];
  assign prod_d        = prod_t'(mul_a) * prod_t'(mul_b);
  assign p_tag_d.first = (k_q == '0);
  assign p_tag_d.last  = (k_q == CNT_MAX);
  assign p_tag_d.i     = i_q;
  assign p_tag_d.j     = j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= (state_q == ST_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p_tag_q <= p_tag_d;
  end

  assign acc_d = p_tag_q.first ? acc_t'(prod_q) : acc_q + acc_t'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_done_q <= 1'b0;
    end else begin
      acc_done_q <= p_valid_q && p_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      acc_q   <= acc_d;
      acc_i_q <= p_tag_q.i;
      acc_j_q <= p_tag_q.j;
    end
  end

  assign shifted = acc_q >>> FRAC_W;
  assign fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);

  always_comb begin
    priority if (fits) begin
      sat_value = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= acc_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_done_q) begin
      res_row_q   <= IDX_IN_W'(acc_i_q);
      res_col_q   <= IDX_IN_W'(acc_j_q);
      res_value_q <= sat_value;
      res_last_q  <= (acc_i_q == CNT_MAX) && (acc_j_q == CNT_MAX);
    end
  end

  assign result_valid_o    = res_valid_q;
  assign out_row_o         = res_row_q;
  assign out_col_o         = res_col_q;
  assign product_element_o = res_value_q;
  assign last_result_o     = res_last_q;

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |->
      (out_row_o == IDX_IN_W'(DIM - 1)) && (out_col_o == IDX_IN_W'(DIM - 1)))
    else $error("last result marked away from the final element");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_load_i) |=> busy_o)
    else $error("final request did not start the product");

  a_term_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> $past(state_q == ST_RUN))
    else $error("product term without a running sequence");

  a_acc_done_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> $past(p_valid_q && p_tag_q.last))
    else $error("sum finished without its final term");

  a_result_follows_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(acc_done_q))
    else $error("result strobe without a finished sum");

endmodule
